@@ rtl/core/tiu_pkg.sv @@
// Shared types and constants for the toy ISA execute unit.
package tiu_pkg;

	localparam int TIU_REG_COUNT = 8;
	localparam int TIU_MEM_WORDS = 5;

	localparam logic [31:0] MEM_BASE = 32'h0000_0100;
	localparam logic [31:0] MEM_LAST = 32'h0000_0110;

	localparam logic [3:0] OP_ADD   = 4'd0;
	localparam logic [3:0] OP_SUB   = 4'd1;
	localparam logic [3:0] OP_AND   = 4'd2;
	localparam logic [3:0] OP_OR    = 4'd3;
	localparam logic [3:0] OP_XOR   = 4'd4;
	localparam logic [3:0] OP_MOV   = 4'd5;
	localparam logic [3:0] OP_CMP   = 4'd6;
	localparam logic [3:0] OP_LOAD  = 4'd7;
	localparam logic [3:0] OP_STORE = 4'd8;
	localparam logic [3:0] OP_BNE   = 4'd9;
	localparam logic [3:0] OP_BEQ   = 4'd10;
	localparam logic [3:0] OP_BAL   = 4'd11;

	typedef struct packed {
		logic n;
		logic z;
		logic c;
		logic v;
	} flags_t;

	// decoded instruction held in the execute stage
	typedef struct packed {
		logic [3:0]  req_type;
		logic [2:0]  first_reg;
		logic [31:0] second_value;
		logic [31:0] third_value;
		logic        third_is_reg;
		logic        mem_ok;
	} exe_ctl_t;

	typedef struct packed {
		logic        status;
		logic [31:0] result;
		logic        taken;
		flags_t      flags;
	} rsp_t;

	typedef struct packed {
		logic rf_we;
		logic mem_we;
	} wr_ctl_t;

endpackage

@@ rtl/core/tiu_if.sv @@
// Request and response channel interfaces of the execute unit.
interface tiu_req_if;
	logic        valid;
	logic        ready;
	logic [3:0]  req_type;
	logic [2:0]  first_reg;
	logic [31:0] second_value;
	logic [31:0] third_value;
	logic        third_is_reg;

	modport source (
		output valid, req_type, first_reg, second_value, third_value, third_is_reg,
		input  ready
	);
	modport sink (
		input  valid, req_type, first_reg, second_value, third_value, third_is_reg,
		output ready
	);
endinterface

interface tiu_rsp_if;
	logic        valid;
	logic        ready;
	logic        status;
	logic [31:0] result_value;
	logic        branch_taken;
	logic        flag_n;
	logic        flag_z;
	logic        flag_c;
	logic        flag_v;

	modport source (
		output valid, status, result_value, branch_taken, flag_n, flag_z, flag_c, flag_v,
		input  ready
	);
	modport sink (
		input  valid, status, result_value, branch_taken, flag_n, flag_z, flag_c, flag_v,
		output ready
	);
endinterface

@@ rtl/core/tiu_regfile.sv @@
// Register file: two registered read ports with write forwarding, one write port.
module tiu_regfile #(
	parameter int REG_COUNT = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        rd_en,
	input  logic [31:0] ra_addr,
	input  logic [31:0] rb_addr,
	output logic [31:0] ra_data,
	output logic [31:0] rb_data,
	input  logic        wr_en,
	input  logic [31:0] wr_addr,
	input  logic [31:0] wr_data
);
	import tiu_pkg::*;

	localparam int RF_AW = $clog2(REG_COUNT);

	logic [31:0]          mem [REG_COUNT];
	logic [REG_COUNT-1:0] vld_q;

	logic             ra_hit, rb_hit, wr_hit;
	logic [RF_AW-1:0] ra_idx, rb_idx, wr_idx;

	assign ra_hit = ra_addr < 32'(REG_COUNT);
	assign rb_hit = rb_addr < 32'(REG_COUNT);
	assign wr_hit = wr_en && (wr_addr < 32'(REG_COUNT));
	assign ra_idx = ra_addr[RF_AW-1:0];
	assign rb_idx = rb_addr[RF_AW-1:0];
	assign wr_idx = wr_addr[RF_AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_hit) begin
			vld_q[wr_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_hit) begin
			mem[wr_idx] <= wr_data;
		end
	end

	// out-of-range index and never-written entries read as zero
	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (!ra_hit) begin
				ra_data <= '0;
			end else if (wr_hit && (wr_idx == ra_idx)) begin
				ra_data <= wr_data;
			end else if (vld_q[ra_idx]) begin
				ra_data <= mem[ra_idx];
			end else begin
				ra_data <= '0;
			end
			if (!rb_hit) begin
				rb_data <= '0;
			end else if (wr_hit && (wr_idx == rb_idx)) begin
				rb_data <= wr_data;
			end else if (vld_q[rb_idx]) begin
				rb_data <= mem[rb_idx];
			end else begin
				rb_data <= '0;
			end
		end
	end

endmodule

@@ rtl/core/tiu_dmem.sv @@
// Data memory: one registered read port with write forwarding, one write port.
module tiu_dmem #(
	parameter int MEM_WORDS = 5
) (
	input  logic                                           clk,
	input  logic                                           arst_n,
	input  logic                                           rd_en,
	input  logic [((MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1)-1:0] rd_idx,
	output logic [31:0]                                    rd_data,
	input  logic                                           wr_en,
	input  logic [((MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1)-1:0] wr_idx,
	input  logic [31:0]                                    wr_data
);
	import tiu_pkg::*;

	logic [31:0]          mem [MEM_WORDS];
	logic [MEM_WORDS-1:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (wr_en) begin
			vld_q[wr_idx] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_idx] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			if (wr_en && (wr_idx == rd_idx)) begin
				rd_data <= wr_data;
			end else if (vld_q[rd_idx]) begin
				rd_data <= mem[rd_idx];
			end else begin
				rd_data <= '0;
			end
		end
	end

endmodule

@@ rtl/core/tiu_alu.sv @@
// Execute logic: ALU, compare flags, load/store and branch resolution.
module tiu_alu (
	input  tiu_pkg::exe_ctl_t ctl,
	input  logic [31:0]       ra,
	input  logic [31:0]       rb,
	input  logic [31:0]       md,
	input  tiu_pkg::flags_t   flags,
	output tiu_pkg::rsp_t     rsp,
	output tiu_pkg::wr_ctl_t  wr
);
	import tiu_pkg::*;

	logic [31:0] b;
	logic [31:0] diff;

	assign b    = ctl.third_is_reg ? rb : ctl.third_value;
	assign diff = ra - ctl.second_value;

	always_comb begin
		rsp       = '0;
		rsp.flags = flags;
		wr        = '0;
		unique case (ctl.req_type)
			OP_ADD: begin
				rsp.result = ra + b;
				wr.rf_we   = 1'b1;
			end
			OP_SUB: begin
				rsp.result = ra - b;
				wr.rf_we   = 1'b1;
			end
			OP_AND: begin
				rsp.result = ra & b;
				wr.rf_we   = 1'b1;
			end
			OP_OR: begin
				rsp.result = ra | b;
				wr.rf_we   = 1'b1;
			end
			OP_XOR: begin
				rsp.result = ra ^ b;
				wr.rf_we   = 1'b1;
			end
			OP_MOV: begin
				rsp.result = ctl.second_value;
				wr.rf_we   = 1'b1;
			end
			OP_CMP: begin
				// port A carries R[first_reg] here
				rsp.result  = diff;
				rsp.flags.n = diff[31];
				rsp.flags.z = (diff == '0);
				rsp.flags.c = (ra >= ctl.second_value);
				rsp.flags.v = ((ra[31] ^ ctl.second_value[31]) & (ra[31] ^ diff[31]));
			end
			OP_LOAD: begin
				if (ctl.mem_ok) begin
					rsp.result = md;
					wr.rf_we   = 1'b1;
				end else begin
					rsp.status = 1'b1;
				end
			end
			OP_STORE: begin
				if (ctl.mem_ok) begin
					rsp.result = ra;
					wr.mem_we  = 1'b1;
				end else begin
					rsp.status = 1'b1;
				end
			end
			OP_BNE: rsp.taken = !flags.z;
			OP_BEQ: rsp.taken = flags.z;
			OP_BAL: rsp.taken = 1'b1;
			default: ;
		endcase
	end

endmodule

@@ rtl/core/toy_isa_execute_unit_top.sv @@
// Top level of the toy ISA execute unit: operand stage, execute and result register.
//
// One instruction per clock sustained while responses are taken. The accepting edge
// registers the register-file and data-memory reads into the execute stage; the edge
// on which execute advances writes back state and loads the result register. Reads
// of a register or word written by the instruction in execute are forwarded, so
// back-to-back dependent instructions run at full rate. The result register lets a
// new instruction enter while a finished result waits; a stalled result holds the
// execute stage and, behind it, the request channel. Register file and data memory
// read as zero until written; there is no clearing pass after reset.
module toy_isa_execute_unit_top #(
	parameter int REG_COUNT = tiu_pkg::TIU_REG_COUNT,
	parameter int MEM_WORDS = tiu_pkg::TIU_MEM_WORDS
) (
	input logic  clk,
	input logic  arst_n,
	tiu_req_if.sink   req,
	tiu_rsp_if.source rsp
);
	import tiu_pkg::*;

	localparam int MEM_AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;

	logic        accept;
	logic        adv;
	logic        s1_valid_q;
	logic        out_valid_q;
	exe_ctl_t    ctl_s1;
	logic [MEM_AW-1:0] mem_idx_s1;
	flags_t      flags_q;
	rsp_t        rsp_c;
	rsp_t        rsp_q;
	wr_ctl_t     wr_c;

	logic        use_rd;
	logic [31:0] ra_addr;
	logic [31:0] mem_off;
	logic [2:0]  mem_word;
	logic        mem_ok;
	logic [31:0] ra_data, rb_data, md_data;

	assign adv       = s1_valid_q && (!out_valid_q || rsp.ready);
	assign req.ready = !s1_valid_q || adv;
	assign accept    = req.valid && req.ready;

	// address decode ahead of the operand register
	assign use_rd   = (req.req_type == OP_CMP) || (req.req_type == OP_STORE);
	assign ra_addr  = use_rd ? 32'(req.first_reg) : req.second_value;
	assign mem_off  = req.second_value - MEM_BASE;
	assign mem_word = mem_off[4:2];
	assign mem_ok   = (req.second_value >= MEM_BASE) && (req.second_value <= MEM_LAST) &&
		(32'(mem_word) < 32'(MEM_WORDS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
			flags_q     <= '0;
		end else begin
			if (accept) begin
				s1_valid_q <= 1'b1;
			end else if (adv) begin
				s1_valid_q <= 1'b0;
			end
			if (adv) begin
				out_valid_q <= 1'b1;
				flags_q     <= rsp_c.flags;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			ctl_s1.req_type     <= req.req_type;
			ctl_s1.first_reg    <= req.first_reg;
			ctl_s1.second_value <= req.second_value;
			ctl_s1.third_value  <= req.third_value;
			ctl_s1.third_is_reg <= req.third_is_reg;
			ctl_s1.mem_ok       <= mem_ok;
			mem_idx_s1          <= MEM_AW'(mem_word);
		end
		if (adv) begin
			rsp_q <= rsp_c;
		end
	end

	tiu_regfile #(
		.REG_COUNT (REG_COUNT)
	) u_regfile (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.ra_addr (ra_addr),
		.rb_addr (req.third_value),
		.ra_data (ra_data),
		.rb_data (rb_data),
		.wr_en   (adv && wr_c.rf_we),
		.wr_addr (32'(ctl_s1.first_reg)),
		.wr_data (rsp_c.result)
	);

	tiu_dmem #(
		.MEM_WORDS (MEM_WORDS)
	) u_dmem (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_idx  (MEM_AW'(mem_word)),
		.rd_data (md_data),
		.wr_en   (adv && wr_c.mem_we),
		.wr_idx  (mem_idx_s1),
		.wr_data (rsp_c.result)
	);

	tiu_alu u_alu (
		.ctl   (ctl_s1),
		.ra    (ra_data),
		.rb    (rb_data),
		.md    (md_data),
		.flags (flags_q),
		.rsp   (rsp_c),
		.wr    (wr_c)
	);

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = rsp_q.status;
	assign rsp.result_value = rsp_q.result;
	assign rsp.branch_taken = rsp_q.taken;
	assign rsp.flag_n       = rsp_q.flags.n;
	assign rsp.flag_z       = rsp_q.flags.z;
	assign rsp.flag_c       = rsp_q.flags.c;
	assign rsp.flag_v       = rsp_q.flags.v;

	// flags move only when a compare leaves execute
	a_flags_cmp_only: assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(flags_q) |-> $past(adv && (ctl_s1.req_type == OP_CMP)))
		else $error("flags changed without a compare");

	a_bad_addr_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !ctl_s1.mem_ok &&
		((ctl_s1.req_type == OP_LOAD) || (ctl_s1.req_type == OP_STORE))
		|-> !wr_c.rf_we && !wr_c.mem_we)
		else $error("out-of-range access writes state");

	a_status_mem_only: assert property (@(posedge clk) disable iff (!arst_n)
		adv && (ctl_s1.req_type != OP_LOAD) && (ctl_s1.req_type != OP_STORE)
		|=> !rsp_q.status)
		else $error("error status on a non-memory beat");

	a_branch_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv && ((ctl_s1.req_type == OP_BNE) || (ctl_s1.req_type == OP_BEQ) ||
		(ctl_s1.req_type == OP_BAL)) |=> (rsp_q.result == '0))
		else $error("branch beat carries a result value");

endmodule

@@ tb/sv/toy_isa_execute_unit_top_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the toy ISA execute unit: directed and random programs.
module toy_isa_execute_unit_top_tb;
	import tiu_pkg::*;

	localparam int CYCLE_LIMIT  = 300000;
	localparam int RANDOM_ITEMS = 500;
	localparam logic [3:0] OP_SPARE_LO = 4'd12;
	localparam logic [3:0] OP_SPARE_HI = 4'd15;

	typedef struct packed {
		logic [3:0]  op;
		logic [2:0]  rd;
		logic [31:0] src;
		logic [31:0] opnd;
		logic        opnd_is_reg;
	} instr_t;

	typedef enum {RX_STREAM, RX_COIN, RX_SLOW, RX_CRAWL} rx_mode_t;

	// architectural mirror of the unit plus the queue of responses still owed
	class exec_scoreboard;
		logic [31:0] gpr [TIU_REG_COUNT];
		logic [31:0] dmem [TIU_MEM_WORDS];
		flags_t      flg;
		rsp_t        pending [$];
		int          errors, checked, n_in, n_cmp, n_faults, n_taken;

		function new();
			foreach (gpr[i]) gpr[i] = '0;
			foreach (dmem[i]) dmem[i] = '0;
			flg = '0;
			errors = 0;
			checked = 0;
			n_in = 0;
			n_cmp = 0;
			n_faults = 0;
			n_taken = 0;
		endfunction

		// indexes past the file read as zero
		function logic [31:0] gpr_rd(logic [31:0] idx);
			return (idx < TIU_REG_COUNT) ? gpr[idx] : 32'h0;
		endfunction

		function void note_input(instr_t ins);
			rsp_t        want;
			logic [31:0] a, b, d, word_idx;
			logic        mem_ok;
			want = '0;
			n_in++;
			case (ins.op)
				OP_ADD, OP_SUB, OP_AND, OP_OR, OP_XOR: begin
					a = gpr_rd(ins.src);
					b = ins.opnd_is_reg ? gpr_rd(ins.opnd) : ins.opnd;
					case (ins.op)
						OP_ADD: want.result = a + b;
						OP_SUB: want.result = a - b;
						OP_AND: want.result = a & b;
						OP_OR:  want.result = a | b;
						default: want.result = a ^ b;
					endcase
					gpr[ins.rd] = want.result;
				end
				OP_MOV: begin
					want.result = ins.src;
					gpr[ins.rd] = want.result;
				end
				OP_CMP: begin
					a = gpr[ins.rd];
					d = a - ins.src;
					want.result = d;
					flg.n = d[31];
					flg.z = (d == 32'h0);
					flg.c = (a >= ins.src);
					flg.v = (a[31] ^ ins.src[31]) & (a[31] ^ d[31]);
					n_cmp++;
				end
				OP_LOAD, OP_STORE: begin
					mem_ok = (ins.src >= MEM_BASE) && (ins.src <= MEM_LAST);
					word_idx = (ins.src - MEM_BASE) >> 2;
					if (mem_ok && word_idx >= TIU_MEM_WORDS)
						mem_ok = 1'b0;
					if (!mem_ok) begin
						want.status = 1'b1;
						n_faults++;
					end else if (ins.op == OP_LOAD) begin
						want.result = dmem[word_idx];
						gpr[ins.rd] = want.result;
					end else begin
						want.result = gpr[ins.rd];
						dmem[word_idx] = want.result;
					end
				end
				OP_BNE: want.taken = !flg.z;
				OP_BEQ: want.taken = flg.z;
				OP_BAL: want.taken = 1'b1;
				default: ;
			endcase
			want.flags = flg;
			if (want.taken)
				n_taken++;
			pending = {pending, want};
		endfunction

		function void cmp_field(string name, logic [31:0] want, logic [31:0] got);
			if (got !== want) begin
				errors++;
				$display("%0t: %s mismatch, expected %h, actual %h", $time, name, want, got);
			end
		endfunction

		function void check_result(rsp_t got);
			rsp_t want;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: response beat with nothing outstanding, result %h",
					$time, got.result);
				return;
			end
			want = pending.pop_front();
			checked++;
			cmp_field("status", 32'(want.status), 32'(got.status));
			cmp_field("result_value", want.result, got.result);
			cmp_field("branch_taken", 32'(want.taken), 32'(got.taken));
			cmp_field("flag_n", 32'(want.flags.n), 32'(got.flags.n));
			cmp_field("flag_z", 32'(want.flags.z), 32'(got.flags.z));
			cmp_field("flag_c", 32'(want.flags.c), 32'(got.flags.c));
			cmp_field("flag_v", 32'(want.flags.v), 32'(got.flags.v));
		endfunction
	endclass

	logic clk;
	logic arst_n;
	int   cycle_count;
	int   burst_left;
	instr_t prog_q [$];
	exec_scoreboard sb = new();

	tiu_req_if req_bus();
	tiu_rsp_if rsp_bus();

	toy_isa_execute_unit_top dut (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_bus),
		.rsp(rsp_bus)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic instr_t make_instr(logic [3:0] op, logic [2:0] rd, logic [31:0] src,
			logic [31:0] opnd, logic is_reg);
		instr_t ins;
		ins.op = op;
		ins.rd = rd;
		ins.src = src;
		ins.opnd = opnd;
		ins.opnd_is_reg = is_reg;
		return ins;
	endfunction

	function automatic void add_instr(instr_t ins);
		prog_q = {prog_q, ins};
	endfunction

	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 6))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'h7FFF_FFFF;
			4: return $urandom_range(0, 16);
			default: return $urandom;
		endcase
	endfunction

	// mostly valid registers, now and then one past the file
	function automatic logic [31:0] pick_index();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(0, 7);
		if ($urandom_range(0, 1))
			return $urandom_range(8, 40);
		return $urandom;
	endfunction

	function automatic logic [31:0] pick_addr();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70)
			return MEM_BASE + $urandom_range(0, 16);
		if (r < 85)
			return MEM_BASE - 16 + $urandom_range(0, 48);
		return $urandom;
	endfunction

	function automatic instr_t random_instr();
		instr_t ins;
		int     r;
		ins.rd = 3'($urandom_range(0, 7));
		ins.opnd = pick_word();
		ins.opnd_is_reg = 1'($urandom_range(0, 1));
		r = $urandom_range(0, 99);
		if (r < 45) begin
			ins.op = 4'($urandom_range(OP_ADD, OP_XOR));
			ins.src = pick_index();
			if (ins.opnd_is_reg)
				ins.opnd = pick_index();
		end else if (r < 55) begin
			ins.op = OP_MOV;
			ins.src = pick_word();
		end else if (r < 67) begin
			// near the live register value so that zero and borrow both turn up
			ins.op = OP_CMP;
			if ($urandom_range(0, 2) == 0)
				ins.src = sb.gpr[ins.rd] + $urandom_range(0, 2) - 1;
			else
				ins.src = pick_word();
		end else if (r < 87) begin
			ins.op = $urandom_range(0, 1) ? OP_LOAD : OP_STORE;
			ins.src = pick_addr();
		end else if (r < 96) begin
			ins.op = 4'($urandom_range(OP_BNE, OP_BAL));
			ins.src = $urandom;
		end else begin
			ins.op = 4'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
			ins.src = $urandom;
		end
		return ins;
	endfunction

	// short programs: compare then branch, store then load back, dependent ALU chains
	task automatic build_group();
		int          kind, n;
		logic [31:0] v, addr;
		logic [2:0]  ra, rb;
		logic        is_reg;
		kind = $urandom_range(0, 9);
		if (kind < 4) begin
			add_instr(random_instr());
		end else if (kind < 6) begin
			ra = 3'($urandom_range(0, 7));
			v = pick_word();
			add_instr(make_instr(OP_MOV, ra, v, $urandom, 1'($urandom_range(0, 1))));
			n = $urandom_range(0, 3);
			if (n == 1)
				v = v + 1;
			else if (n == 2)
				v = v - 1;
			else if (n == 3)
				v = pick_word();
			add_instr(make_instr(OP_CMP, ra, v, $urandom, 1'($urandom_range(0, 1))));
			add_instr(make_instr(4'($urandom_range(OP_BNE, OP_BAL)),
				3'($urandom_range(0, 7)), $urandom, $urandom, 1'($urandom_range(0, 1))));
		end else if (kind < 8) begin
			ra = 3'($urandom_range(0, 7));
			rb = 3'($urandom_range(0, 7));
			addr = pick_addr();
			add_instr(make_instr(OP_MOV, ra, pick_word(), $urandom, 1'b0));
			add_instr(make_instr(OP_STORE, ra, addr, $urandom, 1'($urandom_range(0, 1))));
			if ($urandom_range(0, 1))
				add_instr(random_instr());
			add_instr(make_instr(OP_LOAD, rb, addr, $urandom, 1'($urandom_range(0, 1))));
		end else begin
			ra = 3'($urandom_range(0, 7));
			n = $urandom_range(2, 5);
			repeat (n) begin
				rb = 3'($urandom_range(0, 7));
				is_reg = 1'($urandom_range(0, 1));
				add_instr(make_instr(4'($urandom_range(OP_ADD, OP_XOR)), rb, {29'h0, ra},
					is_reg ? {29'h0, ra} : pick_word(), is_reg));
				ra = rb;
			end
		end
	endtask

	// bursts of back-to-back beats separated by gaps carrying junk with valid low
	task automatic issue(instr_t ins);
		int gap;
		if (burst_left == 0) begin
			gap = $urandom_range(1, 8);
			req_bus.valid <= 1'b0;
			repeat (gap) begin
				req_bus.req_type <= 4'($urandom);
				req_bus.first_reg <= 3'($urandom);
				req_bus.second_value <= $urandom;
				req_bus.third_value <= $urandom;
				req_bus.third_is_reg <= 1'($urandom);
				@(posedge clk);
			end
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 60)
				: $urandom_range(1, 12);
		end
		burst_left--;
		req_bus.valid <= 1'b1;
		req_bus.req_type <= ins.op;
		req_bus.first_reg <= ins.rd;
		req_bus.second_value <= ins.src;
		req_bus.third_value <= ins.opnd;
		req_bus.third_is_reg <= ins.opnd_is_reg;
		@(posedge clk);
		while (!req_bus.ready)
			@(posedge clk);
		sb.note_input(ins);
	endtask

	always @(posedge clk) begin : rsp_monitor
		rsp_t got;
		if (arst_n && rsp_bus.valid && rsp_bus.ready) begin
			got.status = rsp_bus.status;
			got.result = rsp_bus.result_value;
			got.taken = rsp_bus.branch_taken;
			got.flags.n = rsp_bus.flag_n;
			got.flags.z = rsp_bus.flag_z;
			got.flags.c = rsp_bus.flag_c;
			got.flags.v = rsp_bus.flag_v;
			sb.check_result(got);
		end
	end

	initial begin : rsp_stall
		rx_mode_t mode;
		int       span;
		rsp_bus.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			mode = rx_mode_t'($urandom_range(0, 3));
			span = $urandom_range(4, 40);
			repeat (span) begin
				@(posedge clk);
				case (mode)
					RX_STREAM: rsp_bus.ready <= 1'b1;
					RX_COIN:   rsp_bus.ready <= 1'($urandom_range(0, 1));
					RX_SLOW:   rsp_bus.ready <= ($urandom_range(0, 3) == 0);
					default:   rsp_bus.ready <= ($urandom_range(0, 15) == 0);
				endcase
			end
		end
	end

	initial begin : watchdog
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("%0t: timed out after %0d cycles, %0d responses outstanding",
			$time, cycle_count, sb.pending.size());
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin : stimulus
		instr_t ins;
		int     n_random;
		arst_n = 1'b0;
		burst_left = 0;
		req_bus.valid = 1'b0;
		req_bus.req_type = '0;
		req_bus.first_reg = '0;
		req_bus.second_value = '0;
		req_bus.third_value = '0;
		req_bus.third_is_reg = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// operand extremes and wrap-around
		issue(make_instr(OP_MOV, 3'd1, 32'hFFFF_FFFF, 32'h0, 1'b0));
		issue(make_instr(OP_MOV, 3'd2, 32'h0000_0001, 32'h0, 1'b0));
		issue(make_instr(OP_ADD, 3'd3, 32'd1, 32'd2, 1'b1));
		issue(make_instr(OP_SUB, 3'd4, 32'd0, 32'h0000_0001, 1'b0));
		issue(make_instr(OP_AND, 3'd5, 32'd1, 32'h0F0F_0F0F, 1'b0));
		issue(make_instr(OP_OR, 3'd6, 32'd2, 32'd5, 1'b1));
		issue(make_instr(OP_XOR, 3'd7, 32'd1, 32'hFFFF_FFFF, 1'b0));
		// register indexes past the file read as zero
		issue(make_instr(OP_ADD, 3'd0, 32'hFFFF_FFFF, 32'd8, 1'b1));
		// signed overflow and zero on compare, every branch, then a borrow on compare
		issue(make_instr(OP_MOV, 3'd2, 32'h8000_0000, 32'h0, 1'b1));
		issue(make_instr(OP_CMP, 3'd2, 32'h0000_0001, 32'h0, 1'b0));
		issue(make_instr(OP_BNE, 3'd0, 32'h0, 32'h0, 1'b0));
		issue(make_instr(OP_CMP, 3'd0, 32'h0000_0000, 32'h0, 1'b0));
		issue(make_instr(OP_BEQ, 3'd0, 32'h0, 32'h0, 1'b0));
		issue(make_instr(OP_BAL, 3'd0, 32'h0, 32'h0, 1'b0));
		issue(make_instr(OP_CMP, 3'd0, 32'hFFFF_FFFF, 32'h0, 1'b0));
		// memory window edges, an unaligned word and out-of-range addresses
		issue(make_instr(OP_STORE, 3'd1, MEM_BASE, 32'h0, 1'b0));
		issue(make_instr(OP_STORE, 3'd2, MEM_LAST, 32'h0, 1'b0));
		issue(make_instr(OP_STORE, 3'd6, MEM_BASE + 32'h0C, 32'h0, 1'b0));
		issue(make_instr(OP_LOAD, 3'd3, MEM_BASE + 32'h0F, 32'h0, 1'b0));
		issue(make_instr(OP_LOAD, 3'd4, MEM_BASE, 32'h0, 1'b0));
		issue(make_instr(OP_LOAD, 3'd5, MEM_LAST + 32'h1, 32'h0, 1'b0));
		issue(make_instr(OP_STORE, 3'd1, MEM_BASE - 32'h1, 32'h0, 1'b0));
		issue(make_instr(OP_LOAD, 3'd6, 32'hFFFF_FFFF, 32'h0, 1'b0));
		// spare opcodes do nothing
		issue(make_instr(OP_SPARE_LO, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1));
		issue(make_instr(OP_SPARE_HI, 3'd7, 32'h0, 32'h0, 1'b0));

		n_random = 0;
		while (n_random < RANDOM_ITEMS) begin
			build_group();
			while (prog_q.size() != 0) begin
				ins = prog_q.pop_front();
				issue(ins);
				if (ins.op <= OP_BAL)
					n_random++;
			end
		end
		req_bus.valid <= 1'b0;

		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);

		$display("Executed %0d instructions over %0d cycles; %0d responses compared",
			sb.n_in, cycle_count, sb.checked);
		$display("Included %0d compares, %0d memory faults, %0d taken branches; %0d mismatches",
			sb.n_cmp, sb.n_faults, sb.n_taken, sb.errors);
		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
